// File: hw/rtl/usdt_pkg.sv
// Shared types, constants and command codes for the UDP socket demux table.
package usdt_pkg;

  localparam int SOCKET_ENTRIES_DEF = 16;
  localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

  localparam logic [2:0] CMD_LISTEN  = 3'd0;
  localparam logic [2:0] CMD_CONNECT = 3'd1;
  localparam logic [2:0] CMD_CLOSE   = 3'd2;
  localparam logic [2:0] CMD_RX      = 3'd3;
  localparam logic [2:0] CMD_ICMP    = 3'd4;
  localparam logic [2:0] CMD_LINK_UP = 3'd5;
  localparam logic [2:0] CMD_LINK_DN = 3'd6;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_IN_USE     = 3'd1;
  localparam logic [2:0] ST_FULL       = 3'd2;
  localparam logic [2:0] ST_NO_PORT    = 3'd3;
  localparam logic [2:0] ST_NOT_ACTIVE = 3'd4;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd5;
  localparam logic [2:0] ST_BAD_FRAME  = 3'd6;
  localparam logic [2:0] ST_NO_MATCH   = 3'd7;

  localparam logic [1:0] SERR_NONE    = 2'd0;
  localparam logic [1:0] SERR_NO_RESP = 2'd1;
  localparam logic [1:0] SERR_TIMEOUT = 2'd2;
  localparam logic [1:0] SERR_PARAMS  = 2'd3;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [15:0] our_port;
    logic [15:0] peer_port;
    logic [31:0] peer_ip;
    logic [3:0]  sock_handle;
    logic        frame_ok;
    logic        is_broadcast;
    logic [3:0]  icmp_code;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  handle_out;
    logic [15:0] port_out;
    logic        deliver;
    logic        send_unreachable;
    logic        flush_pending;
    logic [1:0]  socket_error;
  } resp_t;

  // controller -> datapath
  typedef struct packed {
    logic load_req;    // capture request
    logic scan_start;  // restart scan, key = request port or candidate
    logic scan_step;   // examine one entry
    logic cand_init;   // candidate = next_dyn, or dyn_port_low if next_dyn is above the range
    logic cand_next;   // advance candidate
    logic do_action;   // execute the command using scan results
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;   // current entry is the last one
    logic cand_done;   // candidate search exhausted
    logic cand_zero;   // skip candidate: port 0, or found in use by its scan
  } sts_t;

  function automatic logic [1:0] icmp_map(input logic [3:0] code, input logic [1:0] old);
    logic [1:0] r;
    begin
      r = old;
      if (code <= 4'd5) r = SERR_NO_RESP;
      else if (code <= 4'd7) r = SERR_TIMEOUT;
      else if (code == 4'd8) r = SERR_PARAMS;
      return r;
    end
  endfunction

endpackage

// File: hw/rtl/usdt_ctrl.sv
// Sequencer for the UDP socket demux table.
module usdt_ctrl import usdt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_fire,
  input  logic [2:0] in_cmd,
  input  logic       out_busy,
  input  sts_t       sts,
  output ctl_t       ctl,
  output logic       idle
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_PSCN = 3'd2;  // port search scan
  localparam logic [2:0] S_PNXT = 3'd3;
  localparam logic [2:0] S_ACT  = 3'd4;
  localparam logic [2:0] S_WAIT = 3'd5;

  logic [2:0] state, state_next;
  logic [2:0] cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cmd <= CMD_LISTEN;
    end else begin
      state <= state_next;
      if (in_fire) cmd <= in_cmd;
    end
  end

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl = '0;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          ctl.load_req = 1'b1;
          ctl.scan_start = 1'b1;
          if (in_cmd == CMD_CONNECT) begin
            ctl.cand_init = 1'b1;
            state_next = S_PNXT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_ACT;
      end
      S_PNXT: begin
        // candidate loaded; check it
        if (sts.cand_done) state_next = S_ACT;
        else if (sts.cand_zero) ctl.cand_next = 1'b1;
        else begin
          ctl.scan_start = 1'b1;
          state_next = S_PSCN;
        end
      end
      S_PSCN: begin
        ctl.scan_step = 1'b1;
        if (sts.scan_last) state_next = S_ACT;
      end
      S_ACT: begin
        // for connect: scan finished without port match -> take; else next
        if (!out_busy) begin
          ctl.do_action = 1'b1;
          state_next = S_WAIT;
        end
      end
      S_WAIT: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
    // connect: candidate found in use by its scan, move on to the next one
    if (state == S_ACT && cmd == CMD_CONNECT && sts.cand_zero) begin
      ctl.do_action = 1'b0;
      ctl.cand_next = 1'b1;
      state_next = S_PNXT;
    end
  end

endmodule

// File: hw/rtl/usdt_dp.sv
// Socket table storage, scan logic and result formation.
module usdt_dp import usdt_pkg::*; #(
  parameter int SOCKET_ENTRIES = SOCKET_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  input  req_t        req_in,
  input  logic [15:0] dyn_port_low,
  input  logic [15:0] dyn_port_high,
  input  logic        icmp_enable,
  output sts_t        sts,
  output logic        res_valid,
  output resp_t       res
);

  localparam int IW = (SOCKET_ENTRIES > 1) ? $clog2(SOCKET_ENTRIES) : 1;
  localparam int CW = $clog2(SOCKET_ENTRIES + 1);

  logic [SOCKET_ENTRIES-1:0] valid;
  logic [15:0] lport_mem [SOCKET_ENTRIES];
  logic [15:0] rport_mem [SOCKET_ENTRIES];
  logic [31:0] raddr_mem [SOCKET_ENTRIES];
  logic [1:0]  err_mem   [SOCKET_ENTRIES];

  req_t        req;
  logic [CW-1:0] idx;
  logic [15:0] key;
  logic        hit, has_free;
  logic [IW-1:0] hit_idx, free_idx;
  logic [15:0] hit_rport;
  logic [31:0] hit_raddr;
  logic [1:0]  hit_err;

  // port search
  logic [15:0] cand, next_dyn;
  logic        wrapped, cand_ok, cand_end;
  logic        link_active;

  logic [IW-1:0] cur;
  assign cur = idx[IW-1:0];

  assign sts.scan_last = (idx == CW'(SOCKET_ENTRIES - 1));
  assign sts.cand_done = cand_end;
  // before the candidate's scan: port 0; after it: port already in use
  assign sts.cand_zero = cand_end ? 1'b0 : ((cand == 16'd0 && !cand_ok) || (cand_ok && hit));

  // cand_ok set once scanning of the candidate starts
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
      hit <= 1'b0;
      has_free <= 1'b0;
      cand_ok <= 1'b0;
    end else begin
      if (ctl.scan_start) begin
        idx <= '0;
        hit <= 1'b0;
        has_free <= 1'b0;
        if (!ctl.load_req) cand_ok <= 1'b1;
      end else if (ctl.scan_step) begin
        if (!sts.scan_last) idx <= idx + CW'(1);
        if (!hit && valid[cur] && lport_mem[cur] == key) begin
          hit <= 1'b1;
        end
        if (!has_free && !valid[cur]) has_free <= 1'b1;
      end
      if (ctl.cand_init || ctl.cand_next) cand_ok <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) req <= req_in;
    if (ctl.scan_start) key <= ctl.load_req ? req_in.our_port : cand;
    if (ctl.scan_step) begin
      if (!hit && valid[cur] && lport_mem[cur] == key) begin
        hit_idx <= cur;
        hit_rport <= rport_mem[cur];
        hit_raddr <= raddr_mem[cur];
        hit_err <= err_mem[cur];
      end
      if (!has_free && !valid[cur]) free_idx <= cur;
    end
  end

  // candidate walk: first pass start..high, then low..start-1
  logic [15:0] cand_start;
  always_ff @(posedge clk) begin
    if (rst) begin
      cand <= '0;
      wrapped <= 1'b0;
      cand_end <= 1'b0;
      cand_start <= '0;
    end else if (ctl.cand_init) begin
      cand_start <= next_dyn;
      if (next_dyn > dyn_port_high) begin
        // pointer above the range: only the low..pointer-1 pass is left
        cand <= dyn_port_low;
        wrapped <= 1'b1;
        cand_end <= (dyn_port_low >= next_dyn);
      end else begin
        cand <= next_dyn;
        wrapped <= 1'b0;
        cand_end <= 1'b0;
      end
    end else if (ctl.cand_next) begin
      if (!wrapped && (cand >= dyn_port_high)) begin
        wrapped <= 1'b1;
        cand <= dyn_port_low;
        cand_end <= (dyn_port_low >= cand_start);
      end else begin
        cand <= cand + 16'd1;
        if (wrapped) cand_end <= (cand + 16'd1 >= cand_start);
        else cand_end <= 1'b0;
      end
    end else if (ctl.cand_init == 1'b0 && ctl.load_req) begin
      cand_end <= 1'b0;
    end
  end

  // action
  resp_t r;
  always_comb begin
    r = '0;
    unique case (req.cmd)
      CMD_LISTEN: begin
        if (!link_active) r.status = ST_NOT_ACTIVE;
        else if (hit) r.status = ST_IN_USE;
        else if (!has_free) r.status = ST_FULL;
        else begin
          r.handle_out = 4'(free_idx);
          r.port_out = req.our_port;
        end
      end
      CMD_CONNECT: begin
        if (!link_active) r.status = ST_NOT_ACTIVE;
        else if (cand_end) r.status = ST_NO_PORT;
        else if (!has_free) r.status = ST_FULL;
        else begin
          r.handle_out = 4'(free_idx);
          r.port_out = cand;
        end
      end
      CMD_CLOSE: begin
        if (!link_active) r.status = ST_NOT_ACTIVE;
        else if (32'(req.sock_handle) >= 32'(SOCKET_ENTRIES) ||
                 !valid[req.sock_handle[IW-1:0]]) r.status = ST_BAD_HANDLE;
        else begin
          r.handle_out = req.sock_handle;
          r.port_out = lport_mem[req.sock_handle[IW-1:0]];
          r.flush_pending = 1'b1;
          r.socket_error = err_mem[req.sock_handle[IW-1:0]];
        end
      end
      CMD_RX: begin
        if (!req.frame_ok) r.status = ST_BAD_FRAME;
        else if (hit && (hit_rport == 16'd0 ||
                 (hit_rport == req.peer_port && hit_raddr == req.peer_ip))) begin
          r.deliver = 1'b1;
          r.handle_out = 4'(hit_idx);
          r.port_out = req.our_port;
        end else begin
          r.status = ST_NO_MATCH;
          r.send_unreachable = icmp_enable && !req.is_broadcast;
        end
      end
      CMD_ICMP: begin
        if (icmp_enable) begin
          if (!hit || hit_rport != req.peer_port || hit_raddr != req.peer_ip)
            r.status = ST_NO_MATCH;
          else begin
            r.handle_out = 4'(hit_idx);
            r.port_out = req.our_port;
            r.flush_pending = 1'b1;
            r.socket_error = icmp_map(req.icmp_code, hit_err);
          end
        end
      end
      CMD_LINK_DN: r.flush_pending = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      link_active <= 1'b0;
      next_dyn <= 16'd49152;
      res_valid <= 1'b0;
    end else begin
      res_valid <= ctl.do_action;
      if (ctl.do_action) begin
        res <= r;
        unique case (req.cmd)
          CMD_LISTEN: if (r.status == ST_OK) valid[free_idx] <= 1'b1;
          CMD_CONNECT: begin
            if (link_active && !cand_end) begin
              next_dyn <= (!wrapped && cand == dyn_port_high) ? dyn_port_low
                                                              : cand + 16'd1;
              if (has_free) valid[free_idx] <= 1'b1;
            end
          end
          CMD_CLOSE: if (r.status == ST_OK) valid[req.sock_handle[IW-1:0]] <= 1'b0;
          CMD_LINK_UP: begin
            link_active <= 1'b1;
            next_dyn <= dyn_port_low;
          end
          CMD_LINK_DN: begin
            link_active <= 1'b0;
            valid <= '0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.do_action) begin
      if (req.cmd == CMD_LISTEN && r.status == ST_OK) begin
        lport_mem[free_idx] <= req.our_port;
        rport_mem[free_idx] <= 16'd0;
        raddr_mem[free_idx] <= LOOPBACK_ADDR;
        err_mem[free_idx] <= SERR_NONE;
      end
      if (req.cmd == CMD_CONNECT && r.status == ST_OK) begin
        lport_mem[free_idx] <= cand;
        rport_mem[free_idx] <= req.peer_port;
        raddr_mem[free_idx] <= req.peer_ip;
        err_mem[free_idx] <= SERR_NONE;
      end
      if (req.cmd == CMD_ICMP && r.flush_pending) err_mem[hit_idx] <= r.socket_error;
    end
  end

endmodule

// File: hw/rtl/udp_socket_demux_table_unit.sv
// Top level of the UDP socket demux table: stream ports, config registers.
// Flow: each accepted command scans the table (one table entry scanned per cycle),
//   then the result is registered and held in the output register until taken.
// Connect scans the table once per ephemeral port candidate, skipping ports in use.
// One transaction at a time: s_tready high
//   only when idle with no result pending. Reset (rst, sync): table empty, link down.
module udp_socket_demux_table_unit import usdt_pkg::*; #(
  parameter int SOCKET_ENTRIES = SOCKET_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // cmd, our_port, peer_port, peer_ip, sock_handle, frame_ok,
  // is_broadcast, icmp_code; 77 bits padded to 80
  input  logic [79:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // status, handle_out, port_out, deliver, send_unreachable,
  // flush_pending, socket_error; 28 bits padded to 32
  output logic [31:0] m_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam logic [1:0] REG_DYN_LOW  = 2'd0;
  localparam logic [1:0] REG_DYN_HIGH = 2'd1;
  localparam logic [1:0] REG_ICMP_EN  = 2'd2;

  logic [15:0] dyn_port_low, dyn_port_high;
  logic        icmp_enable;

  always_ff @(posedge clk) begin
    if (rst) begin
      dyn_port_low <= 16'd49152;
      dyn_port_high <= 16'd65535;
      icmp_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DYN_LOW:  dyn_port_low <= cfg_data;
        REG_DYN_HIGH: dyn_port_high <= cfg_data;
        REG_ICMP_EN:  icmp_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  req_t  req;
  assign req.cmd          = s_tdata[2:0];
  assign req.our_port     = s_tdata[18:3];
  assign req.peer_port    = s_tdata[34:19];
  assign req.peer_ip      = s_tdata[66:35];
  assign req.sock_handle  = s_tdata[70:67];
  assign req.frame_ok     = s_tdata[71];
  assign req.is_broadcast = s_tdata[72];
  assign req.icmp_code    = s_tdata[76:73];

  ctl_t  ctl;
  sts_t  sts;
  logic  idle, res_valid;
  resp_t res;
  logic  in_fire;

  assign s_tready = idle && !m_tvalid;
  assign in_fire = s_tvalid && s_tready;

  usdt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_cmd(req.cmd),
    .out_busy(m_tvalid), .sts(sts), .ctl(ctl), .idle(idle)
  );

  usdt_dp #(.SOCKET_ENTRIES(SOCKET_ENTRIES)) u_dp (
    .clk(clk), .rst(rst), .ctl(ctl), .req_in(req),
    .dyn_port_low(dyn_port_low), .dyn_port_high(dyn_port_high),
    .icmp_enable(icmp_enable), .sts(sts), .res_valid(res_valid), .res(res)
  );

  // output holding register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_valid) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  assign m_tdata = {4'd0, res.socket_error, res.flush_pending, res.send_unreachable,
                    res.deliver, res.port_out, res.handle_out, res.status};

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("accept while result pending");
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !m_tvalid) else $error("result overwrite");
  a_deliver_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && res.deliver |-> res.status == ST_OK) else $error("deliver with error");

endmodule

// File: bench/tb_udp_socket_demux_table_unit.sv
// Testbench for the UDP socket demux table: directed and random command streams.
`timescale 1ns / 100ps

module tb_udp_socket_demux_table_unit;
  import usdt_pkg::*;

  localparam int NUM_SOCK = SOCKET_ENTRIES_DEF;
  localparam int SETTLE_CYCLES = NUM_SOCK + 8;
  localparam logic [1:0] REG_DYN_LOW = 2'd0;
  localparam logic [1:0] REG_DYN_HIGH = 2'd1;
  localparam logic [1:0] REG_ICMP_EN = 2'd2;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  // cmd, our_port, peer_port, peer_ip, sock_handle, frame_ok,
  // is_broadcast, icmp_code (lowest bits first), zero padded
  logic [79:0] s_tdata;
  logic        m_tvalid;
  logic        m_tready;
  // status, handle_out, port_out, deliver, send_unreachable,
  // flush_pending, socket_error (lowest bits first), zero padded
  logic [31:0] m_tdata;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  udp_socket_demux_table_unit uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Shadow socket table and registers
  logic        sk_valid [NUM_SOCK];
  logic [15:0] sk_lport [NUM_SOCK];
  logic [15:0] sk_rport [NUM_SOCK];
  logic [31:0] sk_raddr [NUM_SOCK];
  logic [1:0]  sk_err   [NUM_SOCK];
  logic [15:0] eph_next;
  logic        link_on;
  logic [15:0] dyn_lo;
  logic [15:0] dyn_hi;
  logic        icmp_en;

  resp_t pending_resp[$];
  int    fail_cnt = 0;
  int    send_idle_pct = 0;
  int    recv_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #50ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int find_sock(logic [15:0] port);
    for (int i = 0; i < NUM_SOCK; i++)
      if (sk_valid[i] && sk_lport[i] == port) return i;
    return -1;
  endfunction

  function automatic int free_sock();
    for (int i = 0; i < NUM_SOCK; i++)
      if (!sk_valid[i]) return i;
    return -1;
  endfunction

  // Round-robin ephemeral search: pointer..high, then low..pointer-1
  function automatic logic [15:0] grab_eph_port();
    int lo, hi, cur;
    lo = dyn_lo;
    hi = dyn_hi;
    cur = eph_next;
    for (int p = cur; p <= hi; p++)
      if (p != 0 && find_sock(p[15:0]) < 0) begin
        eph_next = (p == hi) ? dyn_lo : p[15:0] + 16'd1;
        return p[15:0];
      end
    for (int p = lo; p < cur; p++)
      if (p != 0 && find_sock(p[15:0]) < 0) begin
        eph_next = p[15:0] + 16'd1;
        return p[15:0];
      end
    return 16'd0;
  endfunction

  // Applies one command to the shadow table and returns the expected response
  function automatic resp_t demux_predict(req_t r);
    resp_t o;
    int h;
    logic [15:0] p;
    o = '0;
    if (r.cmd <= CMD_CLOSE && !link_on) begin
      o.status = ST_NOT_ACTIVE;
    end else begin
      case (r.cmd)
        CMD_LISTEN: begin
          if (find_sock(r.our_port) >= 0) o.status = ST_IN_USE;
          else begin
            h = free_sock();
            if (h < 0) o.status = ST_FULL;
            else begin
              sk_valid[h] = 1'b1;
              sk_lport[h] = r.our_port;
              sk_rport[h] = 16'd0;
              sk_raddr[h] = LOOPBACK_ADDR;
              sk_err[h] = SERR_NONE;
              o.handle_out = h[3:0];
              o.port_out = r.our_port;
            end
          end
        end
        CMD_CONNECT: begin
          p = grab_eph_port();
          h = free_sock();
          if (p == 16'd0) o.status = ST_NO_PORT;
          else if (h < 0) o.status = ST_FULL;
          else begin
            sk_valid[h] = 1'b1;
            sk_lport[h] = p;
            sk_rport[h] = r.peer_port;
            sk_raddr[h] = r.peer_ip;
            sk_err[h] = SERR_NONE;
            o.handle_out = h[3:0];
            o.port_out = p;
          end
        end
        CMD_CLOSE: begin
          if (!sk_valid[r.sock_handle]) o.status = ST_BAD_HANDLE;
          else begin
            o.handle_out = r.sock_handle;
            o.port_out = sk_lport[r.sock_handle];
            o.flush_pending = 1'b1;
            o.socket_error = sk_err[r.sock_handle];
            sk_valid[r.sock_handle] = 1'b0;
          end
        end
        CMD_RX: begin
          if (!r.frame_ok) o.status = ST_BAD_FRAME;
          else begin
            h = find_sock(r.our_port);
            if (h >= 0 && (sk_rport[h] == 16'd0 ||
                (sk_rport[h] == r.peer_port && sk_raddr[h] == r.peer_ip))) begin
              o.deliver = 1'b1;
              o.handle_out = h[3:0];
              o.port_out = sk_lport[h];
            end else begin
              o.status = ST_NO_MATCH;
              o.send_unreachable = icmp_en && !r.is_broadcast;
            end
          end
        end
        CMD_ICMP: begin
          if (icmp_en) begin
            h = find_sock(r.our_port);
            if (h < 0 || sk_rport[h] != r.peer_port || sk_raddr[h] != r.peer_ip)
              o.status = ST_NO_MATCH;
            else begin
              if (r.icmp_code <= 4'd5) sk_err[h] = SERR_NO_RESP;
              else if (r.icmp_code <= 4'd7) sk_err[h] = SERR_TIMEOUT;
              else if (r.icmp_code == 4'd8) sk_err[h] = SERR_PARAMS;
              o.handle_out = h[3:0];
              o.port_out = sk_lport[h];
              o.flush_pending = 1'b1;
              o.socket_error = sk_err[h];
            end
          end
        end
        CMD_LINK_UP: begin
          link_on = 1'b1;
          eph_next = dyn_lo;
        end
        CMD_LINK_DN: begin
          link_on = 1'b0;
          for (int i = 0; i < NUM_SOCK; i++) sk_valid[i] = 1'b0;
          o.flush_pending = 1'b1;
        end
        default: ;
      endcase
    end
    return o;
  endfunction

  function automatic req_t mk_req(logic [2:0] cmd, logic [15:0] lp, logic [15:0] rp,
                                  logic [31:0] ra, logic [3:0] hd, logic fok,
                                  logic bc, logic [3:0] code);
    req_t r;
    r.cmd = cmd; r.our_port = lp; r.peer_port = rp; r.peer_ip = ra;
    r.sock_handle = hd; r.frame_ok = fok; r.is_broadcast = bc; r.icmp_code = code;
    return r;
  endfunction

  // Send one command; valid stays high across back-to-back transactions
  task automatic send_cmd(req_t r);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, r.icmp_code, r.is_broadcast, r.frame_ok, r.sock_handle,
                r.peer_ip, r.peer_port, r.our_port, r.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_resp.push_back(demux_predict(r));
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_resp.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register write, only with the block idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DYN_LOW:  dyn_lo = val;
      REG_DYN_HIGH: dyn_hi = val;
      REG_ICMP_EN:  icmp_en = val[0];
      default: ;
    endcase
  endtask

  function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_cnt++;
    end
  endfunction

  // Response checker and receiver stall
  always @(posedge clk) begin
    resp_t e;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (pending_resp.size() == 0) begin
          $error("response with no command outstanding: %h", m_tdata);
          fail_cnt++;
        end else begin
          e = pending_resp.pop_front();
          check_field("status", 32'(e.status), 32'(m_tdata[2:0]));
          check_field("handle_out", 32'(e.handle_out), 32'(m_tdata[6:3]));
          check_field("port_out", 32'(e.port_out), 32'(m_tdata[22:7]));
          check_field("deliver", 32'(e.deliver), 32'(m_tdata[23]));
          check_field("send_unreachable", 32'(e.send_unreachable), 32'(m_tdata[24]));
          check_field("flush_pending", 32'(e.flush_pending), 32'(m_tdata[25]));
          check_field("socket_error", 32'(e.socket_error), 32'(m_tdata[27:26]));
        end
      end
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Link state, listen/connect/close/rx/icmp basics and their corner cases
  task automatic test_directed();
    send_cmd(mk_req(CMD_LISTEN, 16'd80, 0, 0, 0, 0, 0, 0));          // link down
    send_cmd(mk_req(CMD_CONNECT, 0, 16'd53, 32'h0A000001, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_CLOSE, 0, 0, 0, 4'd0, 0, 0, 0));
    send_cmd(mk_req(CMD_LINK_UP, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_LISTEN, 16'd0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_LISTEN, 16'hFFFF, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_LISTEN, 16'hFFFF, 0, 0, 0, 0, 0, 0));        // port in use
    send_cmd(mk_req(CMD_CONNECT, 0, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_RX, 16'hFFFF, 16'h1234, 32'h01020304, 0, 1, 0, 0)); // listener
    send_cmd(mk_req(CMD_RX, 16'd49152, 16'hFFFF, 32'hFFFFFFFF, 0, 1, 0, 0)); // peer ok
    send_cmd(mk_req(CMD_RX, 16'd49152, 16'hFFFE, 32'hFFFFFFFF, 0, 1, 0, 0)); // peer bad
    send_cmd(mk_req(CMD_RX, 16'd7, 16'd1, 32'd1, 0, 1, 1, 0));      // no match, bcast
    send_cmd(mk_req(CMD_RX, 16'd7, 16'd1, 32'd1, 0, 0, 0, 0));      // bad frame
    send_cmd(mk_req(CMD_ICMP, 16'd49152, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 4'd6));
    send_cmd(mk_req(CMD_ICMP, 16'd49152, 16'hFFFF, 32'hFFFFFFFF, 0, 0, 0, 4'd15));
    send_cmd(mk_req(CMD_ICMP, 16'hFFFF, 16'd0, 32'd0, 0, 0, 0, 4'd0)); // listener: no match
    send_cmd(mk_req(CMD_CLOSE, 0, 0, 0, 4'd2, 0, 0, 0));
    send_cmd(mk_req(CMD_CLOSE, 0, 0, 0, 4'd15, 0, 0, 0));            // bad handle
    send_cmd(mk_req(3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 4'hF, 1, 1, 4'hF));
    for (int i = 0; i < NUM_SOCK; i++)                               // fill the table
      send_cmd(mk_req(CMD_LISTEN, 16'd1000 + i[15:0], 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_CONNECT, 0, 16'd9, 32'd9, 0, 0, 0, 0));     // full, pointer moves
    send_cmd(mk_req(CMD_LINK_DN, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Register extremes: single-port range, inverted range, ICMP disabled
  task automatic test_registers();
    write_reg(REG_DYN_LOW, 16'd1);
    write_reg(REG_DYN_HIGH, 16'd1);
    send_cmd(mk_req(CMD_LINK_UP, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_CONNECT, 0, 16'd5, 32'd5, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_CONNECT, 0, 16'd5, 32'd5, 0, 0, 0, 0));     // no free port
    write_reg(REG_DYN_LOW, 16'd700);
    write_reg(REG_DYN_HIGH, 16'd690);
    send_cmd(mk_req(CMD_LINK_UP, 0, 0, 0, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_CONNECT, 0, 16'd5, 32'd5, 0, 0, 0, 0));
    write_reg(REG_ICMP_EN, 16'd0);
    send_cmd(mk_req(CMD_RX, 16'd3, 16'd3, 32'd3, 0, 1, 0, 0));
    send_cmd(mk_req(CMD_ICMP, 16'd1, 16'd5, 32'd5, 0, 0, 0, 4'd8));
    write_reg(REG_ICMP_EN, 16'd1);
    write_reg(REG_DYN_LOW, 16'd65530);
    write_reg(REG_DYN_HIGH, 16'hFFFF);
    send_cmd(mk_req(CMD_LINK_UP, 0, 0, 0, 0, 0, 0, 0));
    for (int i = 0; i < 8; i++)                                      // wraps at the top
      send_cmd(mk_req(CMD_CONNECT, 0, 16'd5, 32'd5, 0, 0, 0, 0));
    // pointer left above a lowered range: search restarts at the low end
    write_reg(REG_DYN_LOW, 16'd65520);
    write_reg(REG_DYN_HIGH, 16'd65525);
    for (int i = 0; i < 3; i++)
      send_cmd(mk_req(CMD_CONNECT, 0, 16'd5, 32'd5, 0, 0, 0, 0));
    send_cmd(mk_req(CMD_LINK_DN, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // Mostly traffic aimed at live sockets; some pure noise
  function automatic req_t rand_req();
    req_t r;
    int h, pick;
    r = mk_req(3'($urandom_range(6)), 16'($urandom_range(65535)),
               16'($urandom_range(65535)), $urandom(), 4'($urandom_range(15)),
               $urandom_range(99) < 90, $urandom_range(99) < 20,
               4'($urandom_range(15)));
    pick = $urandom_range(99);
    if (pick < 8) r.cmd = CMD_LISTEN;
    else if (pick < 20) r.cmd = CMD_CONNECT;
    else if (pick < 30) r.cmd = CMD_CLOSE;
    else if (pick < 70) r.cmd = CMD_RX;
    else if (pick < 92) r.cmd = CMD_ICMP;
    else if (pick < 96) r.cmd = CMD_LINK_UP;
    else if (pick < 98) r.cmd = CMD_LINK_DN;
    else r.cmd = 3'd7;
    if (r.cmd == CMD_LISTEN && $urandom_range(3) != 0)
      r.our_port = 16'(2000 + $urandom_range(24));
    if (r.cmd == CMD_CONNECT && $urandom_range(1)) begin
      r.peer_port = 16'(53 + $urandom_range(3));
      r.peer_ip = 32'hC0A80000 + $urandom_range(3);
    end
    h = $urandom_range(NUM_SOCK - 1);
    if ((r.cmd == CMD_RX || r.cmd == CMD_ICMP) && sk_valid[h] && $urandom_range(99) < 80) begin
      r.our_port = sk_lport[h];
      if ($urandom_range(9) != 0) begin
        r.peer_port = sk_rport[h];
        r.peer_ip = sk_raddr[h];
      end
    end
    if (r.cmd == CMD_CLOSE && $urandom_range(3) != 0) begin
      for (int i = 0; i < NUM_SOCK; i++)
        if (sk_valid[(h + i) % NUM_SOCK]) begin
          r.sock_handle = 4'((h + i) % NUM_SOCK);
          break;
        end
    end
    return r;
  endfunction

  task automatic test_random(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) drain();  // let everything come back before going on
      send_cmd(rand_req());
    end
    drain();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    for (int i = 0; i < NUM_SOCK; i++) begin
      sk_valid[i] = 1'b0; sk_lport[i] = '0; sk_rport[i] = '0;
      sk_raddr[i] = '0; sk_err[i] = '0;
    end
    dyn_lo = 16'd49152;
    dyn_hi = 16'hFFFF;
    icmp_en = 1'b1;
    eph_next = dyn_lo;
    link_on = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_registers();
    // narrow range so the port search wraps and skips ports in use under traffic
    write_reg(REG_DYN_LOW, 16'd50000);
    write_reg(REG_DYN_HIGH, 16'd50019);
    send_cmd(mk_req(CMD_LINK_UP, 0, 0, 0, 0, 0, 0, 0));
    test_random(230, 0, 0);
    test_random(220, 82, 0);
    write_reg(REG_ICMP_EN, 16'd0);
    test_random(220, 0, 82);
    write_reg(REG_ICMP_EN, 16'd1);
    write_reg(REG_DYN_LOW, 16'd49152);
    write_reg(REG_DYN_HIGH, 16'hFFFF);
    test_random(230, 21, 21);

    drain();
    if (fail_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: udp_socket_demux_table_unit.f
hw/rtl/usdt_pkg.sv
hw/rtl/usdt_ctrl.sv
hw/rtl/usdt_dp.sv
hw/rtl/udp_socket_demux_table_unit.sv
bench/tb_udp_socket_demux_table_unit.sv
